@@ rtl/keyframe_color_ramp_defines.svh @@
// Assertion macros for the keyframe color ramp checker.
`ifndef KEYFRAME_COLOR_RAMP_DEFINES_SVH
`define KEYFRAME_COLOR_RAMP_DEFINES_SVH

// Implication checked on every clock edge, muted while in reset.
`define KCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define KCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/kcr_pkg.sv @@
// ----------------------------------------------------------------------------
// kcr_pkg
// Shared types and constants for the keyframe color ramp.
// ----------------------------------------------------------------------------
`default_nettype none
package kcr_pkg;
  localparam int MaxKeys   = 6;
  localparam int TimeBits  = 16;
  localparam int KeyBits   = 48;
  localparam int CntBits   = 3;
  localparam int IdxBits   = 3;
  localparam int QueueDepth = 2;
  // Product (t-ta)*(b-a): 16 x 9 signed magnitude, kept as magnitude.
  localparam int ProdBits  = TimeBits + 8;

  localparam logic [KeyBits-1:0] KeyReset = 48'h01F4_FFFF_FFFF;
  localparam logic [CntBits-1:0] CountReset = 3'd2;

  localparam logic [IdxBits-1:0] RegCount = 3'd0;

  typedef logic [KeyBits-1:0] key_t;

  // Item handed from the segment finder to the interpolator.
  typedef struct packed {
    logic                in_range;
    logic                flat;
    logic [TimeBits-1:0] dt;
    logic [TimeBits-1:0] span;
    logic [31:0]         color_a;
    logic [31:0]         color_b;
  } seg_item_t;

  // Per-channel lane state inside the divider pipeline.
  typedef struct packed {
    logic                neg;
    logic [7:0]          a;
    logic [ProdBits-1:0] rem;
    logic [ProdBits-1:0] quo;
  } lane_t;

  // Per-item sideband through the divider pipeline.
  typedef struct packed {
    logic                in_range;
    logic                flat;
    logic [TimeBits-1:0] span;
  } side_t;
endpackage
`default_nettype wire

@@ rtl/kcr_front.sv @@
// ----------------------------------------------------------------------------
// kcr_front
// Accept a query time, pick the first covering segment, register the result.
// ----------------------------------------------------------------------------
`default_nettype none
module kcr_front
  import kcr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [TimeBits-1:0] in_time,
  input  wire logic [CntBits-1:0]  count,
  input  wire key_t                keys [MaxKeys],
  output logic                     out_valid,
  input  wire logic                out_ready,
  output seg_item_t                out_item
);
  seg_item_t item_next;
  logic [CntBits-1:0] n_eff;
  logic [TimeBits-1:0] ta, tb;
  logic found;

  always_comb begin
    n_eff = count;
    if (count < CntBits'(2)) n_eff = CntBits'(2);
    if (count > CntBits'(MaxKeys)) n_eff = CntBits'(MaxKeys);
    item_next = '0;
    found = 1'b0;
    for (int i = 0; i < MaxKeys - 1; i++) begin
      ta = keys[i][47:32];
      tb = keys[i+1][47:32];
      if (!found && (CntBits'(i + 1) < n_eff) && in_time >= ta && in_time <= tb) begin
        found = 1'b1;
        item_next.in_range = 1'b1;
        item_next.flat     = (ta == tb);
        item_next.dt       = in_time - ta;
        item_next.span     = tb - ta;
        item_next.color_a  = keys[i][31:0];
        item_next.color_b  = keys[i+1][31:0];
      end
    end
  end

  // Take nothing while in reset.
  assign in_ready = !rst && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end
endmodule
`default_nettype wire

@@ rtl/kcr_queue.sv @@
// ----------------------------------------------------------------------------
// kcr_queue
// Short queue between the segment finder and the interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
module kcr_queue
  import kcr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire seg_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output seg_item_t      out_item
);
  seg_item_t slots [QueueDepth];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic push, pop;

  assign in_ready  = fill != 2'(QueueDepth);
  assign out_valid = fill != 2'd0;
  assign out_item  = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end
endmodule
`default_nettype wire

@@ rtl/kcr_back.sv @@
// ----------------------------------------------------------------------------
// kcr_back
// Interpolate four channels: multiply, then a pipelined restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module kcr_back
  import kcr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire seg_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [31:0]    out_color,
  output logic           out_in_range
);
  // Stages: 0 multiply, 1..ProdBits divide one quotient bit each, last result.
  localparam int Stages = ProdBits + 1;

  logic  vld  [Stages];
  side_t side [Stages];
  lane_t lane [Stages][4];
  logic  adv;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < Stages; s++) vld[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int s = 1; s < Stages; s++) vld[s] <= vld[s-1];
      out_valid <= vld[Stages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].in_range <= in_item.in_range;
      side[0].flat     <= in_item.flat;
      side[0].span     <= in_item.span;
      for (int c = 0; c < 4; c++) begin
        logic [7:0] a, b;
        logic [8:0] d;
        a = in_item.color_a[31-8*c -: 8];
        b = in_item.color_b[31-8*c -: 8];
        d = (b >= a) ? 9'(b - a) : 9'(a - b);
        lane[0][c].neg <= b < a;
        lane[0][c].a   <= a;
        lane[0][c].rem <= '0;
        lane[0][c].quo <= ProdBits'(in_item.dt) * ProdBits'(d);
      end
      for (int s = 1; s < Stages; s++) begin
        side[s] <= side[s-1];
        for (int c = 0; c < 4; c++) begin
          logic [ProdBits:0] r;
          logic [ProdBits-1:0] q;
          q = lane[s-1][c].quo;
          r = {lane[s-1][c].rem, q[ProdBits-1]};
          q = {q[ProdBits-2:0], 1'b0};
          if (r >= (ProdBits+1)'(side[s-1].span) && side[s-1].span != '0) begin
            r = r - (ProdBits+1)'(side[s-1].span);
            q[0] = 1'b1;
          end
          lane[s][c].neg <= lane[s-1][c].neg;
          lane[s][c].a   <= lane[s-1][c].a;
          lane[s][c].rem <= r[ProdBits-1:0];
          lane[s][c].quo <= q;
        end
      end
    end
  end

  // Result: floor for negative slope rounds away when the remainder is nonzero.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_in_range <= side[Stages-1].in_range;
      for (int c = 0; c < 4; c++) begin
        logic [7:0] q8, v;
        q8 = lane[Stages-1][c].quo[7:0] + 8'(lane[Stages-1][c].neg &&
             lane[Stages-1][c].rem != '0);
        v = lane[Stages-1][c].neg ? lane[Stages-1][c].a - q8 : lane[Stages-1][c].a + q8;
        if (side[Stages-1].flat) v = lane[Stages-1][c].a;
        if (!side[Stages-1].in_range) v = 8'd0;
        out_color[31-8*c -: 8] <= v;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/keyframe_color_ramp.sv @@
// ----------------------------------------------------------------------------
// keyframe_color_ramp
// Piecewise linear RGBA gradient over up to six configured keyframes.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  s_axis   | in  | tdata[15:0] query_time
//  m_axis   | out | tdata red,green,blue,alpha (low up); tuser in_range
//  cfg      | in  | index 0 keyframe_count, 1..6 key_0..key_5
//
// One item per clock sustained while m_axis does not stall. An accepted item
// reaches tvalid through the finder register, one queue slot, the multiply stage, 24
// pipelined divider steps and the result register.
// Synchronous reset clears all valid flags and loads the keyframe reset table;
// while rst is high no item and no register write is taken.
// A stall on m_axis freezes the back pipeline; the queue decouples the finder.
`default_nettype none
module keyframe_color_ramp
  import kcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // query_time
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // red, green, blue, alpha
  output logic             m_axis_tuser,   // in_range
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  logic [CntBits-1:0] count;
  key_t keys [MaxKeys];
  seg_item_t f_item, q_item;
  logic f_valid, f_ready, q_valid, q_ready;
  logic [31:0] color;

  assign cfg_ready = !rst;

  // Hold the configuration registers; ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CountReset;
      for (int i = 0; i < MaxKeys; i++) keys[i] <= KeyReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegCount) count <= cfg_data[CntBits-1:0];
      for (int i = 0; i < MaxKeys; i++)
        if (cfg_index == IdxBits'(i + 1)) keys[i] <= cfg_data;
    end
  end

  kcr_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_time(s_axis_tdata[TimeBits-1:0]), .count, .keys,
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  kcr_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  kcr_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_color(color), .out_in_range(m_axis_tuser)
  );

  // Repack: red in the lowest byte.
  assign m_axis_tdata = {color[7:0], color[15:8], color[23:16], color[31:24]};
endmodule
`default_nettype wire

@@ rtl/kcr_checker.sv @@
// ----------------------------------------------------------------------------
// kcr_checker
// Port-level checks for the keyframe color ramp.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyframe_color_ramp_defines.svh"
module kcr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  `KCR_ASSERT_IMPL(out_of_range_black, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0, "out of range item not black")
  `KCR_ASSERT_NEXT(stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
  `KCR_ASSERT_NEXT(no_valid_after_reset, clk, 1'b0, rst, !m_axis_tvalid, "valid right after reset")
endmodule
bind keyframe_color_ramp kcr_checker u_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire
